// ===== design/llps_pkg.sv =====
// Shared types, codes and sizes for the LL(1) parse engine.
`timescale 1ns / 1ps
package llps_pkg;

    localparam int NT_W      = 6;
    localparam int T_W       = 6;
    localparam int PROD_W    = 8;
    localparam int POS_W     = 3;
    localparam int LEN_W     = 4;
    localparam int SYM_W     = 8;
    localparam int TBL_AW    = NT_W + T_W;
    localparam int RHS_AW    = PROD_W + POS_W;
    localparam int SP_W      = 9;
    localparam int STK_AW    = 8;
    localparam int STACK_DEPTH = 256;
    localparam int RHS_MAX   = 8;
    localparam int EXP_W     = 6;
    localparam int EXPANSION_LIMIT = 63;
    localparam int IN_W      = 2 + NT_W + T_W + PROD_W + 1 + POS_W + LEN_W + 2 + NT_W;
    localparam int QDEPTH    = 2;

    typedef enum logic [1:0] {
        OP_TABLE = 2'd0,
        OP_RHS   = 2'd1,
        OP_PUSH  = 2'd2,
        OP_PARSE = 2'd3
    } op_t;

    localparam logic [1:0] KIND_TERM    = 2'd1;
    localparam logic [1:0] KIND_NONTERM = 2'd2;

    typedef enum logic [2:0] {
        ST_EXPAND   = 3'd0,
        ST_MATCH    = 3'd1,
        ST_ACK      = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_MISS     = 3'd4,
        ST_MISMATCH = 3'd5,
        ST_OVERFLOW = 3'd6
    } status_t;

    // One classified command from the front end.
    typedef struct packed {
        op_t                opcode;
        logic [TBL_AW-1:0]  tbl_addr;
        logic [T_W-1:0]     lookahead;
        logic [PROD_W-1:0]  prod;
        logic               entry_valid;
        logic [POS_W-1:0]   pos;
        logic [LEN_W-1:0]   len;
        logic [SYM_W-1:0]   sym;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SYM,
        S_LOOK,
        S_LEN,
        S_PUSH,
        S_OUT,
        S_CLR
    } eng_state_t;

endpackage

// ===== design/llps_front.sv =====
// Front end: accepts input transfers, clamps lengths and queues commands.
`timescale 1ns / 1ps
module llps_front
    import llps_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output cmd_t            cmd
);

    cmd_t              q_mem [QDEPTH];
    logic              wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    cmd_t              in_cmd;
    logic [LEN_W-1:0]  raw_len;
    logic              push, pop;

    // Unpack the input fields into a command.
    always_comb
    begin
        raw_len              = s_tdata[29:26];
        in_cmd.opcode        = op_t'(s_tdata[1:0]);
        in_cmd.tbl_addr      = {s_tdata[7:2], s_tdata[13:8]};
        in_cmd.lookahead     = s_tdata[13:8];
        in_cmd.prod          = s_tdata[21:14];
        in_cmd.entry_valid   = s_tdata[22];
        in_cmd.pos           = s_tdata[25:23];
        in_cmd.len           = (raw_len > LEN_W'(RHS_MAX)) ? LEN_W'(RHS_MAX) : raw_len;
        in_cmd.sym           = {s_tdata[31:30], s_tdata[37:32]};
    end

    assign s_tready  = (cnt_reg != 2'(QDEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QDEPTH))
        else $error("command queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(QDEPTH)) |-> !s_tready)
        else $error("queue accepts when full");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count missed a write");

endmodule

// ===== design/llps_engine.sv =====
// Back end: table, rhs and stack memories with the parse sequencer.
`timescale 1ns / 1ps
module llps_engine
    import llps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    localparam int TBL_N = 1 << TBL_AW;

    // Memories. Each table word holds a valid bit above the production.
    logic [PROD_W:0]   tbl_mem [TBL_N];
    logic [SYM_W-1:0]  rhs_mem [1 << RHS_AW];
    logic [LEN_W-1:0]  len_mem [1 << PROD_W];
    logic [SYM_W-1:0]  stk_mem [STACK_DEPTH];

    eng_state_t        state_reg, state_next;
    cmd_t              cur_reg;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic [SYM_W-1:0]  sym_rd_reg;
    logic [PROD_W-1:0] tbl_rd_reg, prod_reg, prod_next;
    logic              tbl_hit_reg;
    logic [LEN_W-1:0]  len_rd_reg, cnt_reg, cnt_next;
    logic [SYM_W-1:0]  rhs_rd_reg;
    logic              rhs_rd_vld_reg, rhs_rd_vld_next;
    status_t           ost_reg, ost_next;
    logic [PROD_W-1:0] oprod_reg, oprod_next;
    logic              olast_reg, olast_next;
    logic              ovld_reg, ovld_next;
    eng_state_t        ret_reg, ret_next;
    logic [TBL_AW-1:0] clr_reg, clr_next;

    logic              stk_we;
    logic [STK_AW-1:0] stk_wa, stk_ra;
    logic [SYM_W-1:0]  stk_wd;
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_wa;
    logic [PROD_W:0]   tbl_wd;
    logic              take;
    logic [RHS_AW-1:0] rhs_ra;
    logic [SP_W:0]     fit;

    assign cmd_ready = (state_reg == S_IDLE) && !ovld_reg;
    assign take      = cmd_valid && cmd_ready;
    assign m_tvalid  = ovld_reg;
    assign m_tdata   = {5'd0, oprod_reg, ost_reg};
    assign m_tlast   = olast_reg;
    assign fit       = {1'b0, sp_reg} + (SP_W + 1)'(len_rd_reg);
    assign stk_ra    = STK_AW'(sp_reg - SP_W'(1));
    assign rhs_ra    = {prod_reg, POS_W'(cnt_reg - LEN_W'(1))};

    // Next state and datapath.
    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        exp_next        = exp_reg;
        prod_next       = prod_reg;
        cnt_next        = cnt_reg;
        rhs_rd_vld_next = 1'b0;
        ost_next        = ost_reg;
        oprod_next      = oprod_reg;
        olast_next      = olast_reg;
        ovld_next       = ovld_reg && !m_tready;
        ret_next        = ret_reg;
        clr_next        = clr_reg;
        stk_we          = 1'b0;
        stk_wa          = STK_AW'(sp_reg);
        stk_wd          = cur_reg.sym;
        tbl_we          = 1'b0;
        tbl_wa          = cmd.tbl_addr;
        tbl_wd          = {cmd.entry_valid, cmd.prod};
        case (state_reg)
            S_CLR:
            begin
                // Zero one table word per cycle after reset.
                tbl_we   = 1'b1;
                tbl_wa   = clr_reg;
                tbl_wd   = '0;
                clr_next = clr_reg + TBL_AW'(1);
                if (clr_reg == TBL_AW'(TBL_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    olast_next = 1'b1;
                    oprod_next = '0;
                    ost_next   = ST_ACK;
                    exp_next   = '0;
                    case (cmd.opcode)
                        OP_PARSE: state_next = S_POP;
                        OP_TABLE:
                        begin
                            tbl_we    = 1'b1;
                            ovld_next = 1'b1;
                        end
                        OP_PUSH:
                        begin
                            if (sp_reg >= SP_W'(STACK_DEPTH))
                            begin
                                ost_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                stk_we  = 1'b1;
                                stk_wd  = cmd.sym;
                                sp_next = sp_reg + SP_W'(1);
                            end
                            ovld_next = 1'b1;
                        end
                        default: ovld_next = 1'b1;
                    endcase
                end
            end
            S_POP:
            begin
                if (!ovld_reg)
                begin
                    if (sp_reg == '0)
                    begin
                        ost_next   = ST_EMPTY;
                        oprod_next = '0;
                        olast_next = 1'b1;
                        ovld_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sp_next    = sp_reg - SP_W'(1);
                        state_next = S_SYM;
                    end
                end
            end
            S_SYM:
            begin
                // Stack read data is now registered.
                if (sym_rd_reg[7:6] == KIND_TERM)
                begin
                    ost_next   = (sym_rd_reg[5:0] == cur_reg.lookahead) ? ST_MATCH : ST_MISMATCH;
                    oprod_next = '0;
                    olast_next = 1'b1;
                    ovld_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sym_rd_reg[7:6] == KIND_NONTERM)
                begin
                    state_next = S_LOOK;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_LOOK:
            begin
                prod_next = tbl_rd_reg;
                if (!tbl_hit_reg)
                begin
                    ost_next   = ST_MISS;
                    oprod_next = '0;
                    olast_next = 1'b1;
                    ovld_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (exp_reg == EXP_W'(EXPANSION_LIMIT))
                begin
                    ost_next   = ST_OVERFLOW;
                    oprod_next = '0;
                    olast_next = 1'b1;
                    ovld_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (fit > (SP_W + 1)'(STACK_DEPTH))
                begin
                    ost_next   = ST_OVERFLOW;
                    oprod_next = '0;
                    olast_next = 1'b1;
                    ovld_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = len_rd_reg;
                    exp_next   = exp_reg + EXP_W'(1);
                    ret_next   = S_PUSH;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ovld_reg)
                begin
                    ost_next   = ST_EXPAND;
                    oprod_next = prod_reg;
                    olast_next = 1'b0;
                    ovld_next  = 1'b1;
                    state_next = ret_reg;
                end
            end
            S_PUSH:
            begin
                // Read one rhs symbol, write it next cycle; last first.
                if (rhs_rd_vld_reg)
                begin
                    stk_we  = 1'b1;
                    stk_wd  = rhs_rd_reg;
                    sp_next = sp_reg + SP_W'(1);
                end
                if (cnt_reg != '0)
                begin
                    rhs_rd_vld_next = 1'b1;
                    cnt_next        = cnt_reg - LEN_W'(1);
                end
                else if (!rhs_rd_vld_reg)
                begin
                    state_next = S_POP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            sp_reg         <= '0;
            ovld_reg       <= 1'b0;
            rhs_rd_vld_reg <= 1'b0;
            clr_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            ovld_reg       <= ovld_next;
            rhs_rd_vld_reg <= rhs_rd_vld_next;
            clr_reg        <= clr_next;
        end
    end

    // Payload registers and memory ports.
    always_ff @(posedge clk)
    begin
        exp_reg   <= exp_next;
        prod_reg  <= prod_next;
        cnt_reg   <= cnt_next;
        ost_reg   <= ost_next;
        oprod_reg <= oprod_next;
        olast_reg <= olast_next;
        ret_reg   <= ret_next;
        if (take)
        begin
            cur_reg <= cmd;
        end
        if (tbl_we)
        begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        if (take && cmd.opcode == OP_RHS)
        begin
            len_mem[cmd.prod] <= cmd.len;
            rhs_mem[{cmd.prod, cmd.pos}] <= cmd.sym;
        end
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        sym_rd_reg  <= stk_mem[stk_ra];
        {tbl_hit_reg, tbl_rd_reg} <= tbl_mem[{sym_rd_reg[5:0], cur_reg.lookahead}];
        len_rd_reg  <= len_mem[prod_next];
        rhs_rd_reg  <= rhs_mem[rhs_ra];
    end

    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ost_reg == ST_EXPAND) |-> !m_tlast)
        else $error("expansion flagged as last");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SYM) |-> $past(state_reg) == S_POP)
        else $error("symbol check without pop");

endmodule

// ===== design/ll1_predictive_parse_step.sv =====
// Top level of the LL(1) parse engine: front queue and back-end sequencer.
// Load items run from input to result; a new item is taken only once the last result is taken.
// Parse items pop past nulls, report and push each expansion (less work for an empty
// one) and end with a final result; output stalls hold them; one item at a time.
// Rate is set by the stack memory and the sequencer.
// Reset clears the stack pointer and queue, then a pass zeroes all 4096 table words.
`timescale 1ns / 1ps
module ll1_predictive_parse_step
    import llps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode, nonterminal_id, terminal_id, production_id, entry_valid,
    // rhs_position, rhs_length, symbol_kind, symbol_id (low to high)
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, applied_production (low to high)
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    llps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata[IN_W-1:0]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    llps_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the LL(1) parse engine: stream driver, monitor and predictor.
`timescale 1ns / 1ps
module tb_top;
    import llps_pkg::*;

    localparam logic [1:0] KIND_NULL = 2'd0;
    localparam logic [1:0] KIND_RSVD = 2'd3;
    localparam int DIRECTED_LIMIT = 410;

    typedef struct {
        op_t         opcode;
        logic [5:0]  nt;
        logic [5:0]  term;
        logic [7:0]  prod;
        logic        ev;
        logic [2:0]  pos;
        logic [3:0]  len;
        logic [1:0]  kind;
        logic [5:0]  sid;
    } load_item_t;

    typedef struct {
        status_t     status;
        logic [7:0]  prod;
        logic        last;
    } parse_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // Pending input words and the results they are predicted to cause.
    logic [39:0]   pending_words[$];
    parse_result_t expected_results[$];

    // Predictor copy of the engine state.
    logic [8:0]  grammar_table[4096];
    logic [7:0]  rhs_syms[2048];
    bit          rhs_sym_known[2048];
    logic [3:0]  rhs_lens[256];
    bit          rhs_len_known[256];
    logic [7:0]  sym_stack[256];
    int          stack_ptr;

    int  error_count;
    int  result_count;
    int  item_count;
    int  expansion_count;
    bit  stim_done;

    ll1_predictive_parse_step u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock, 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, and whole stretches with none.
    bit quiet_stretch;
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_stretch || r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Builds one expected result.
    function automatic parse_result_t result_of(status_t st, logic [7:0] prod, logic last);
        parse_result_t res;
        res.status = st;
        res.prod   = prod;
        res.last   = last;
        return res;
    endfunction

    // Runs one parse against the predictor state. Refuses (ok = 0) and rolls
    // back when the parse would read a right-hand side that was never written.
    task automatic run_parse(input logic [5:0] lookahead, output bit ok);
        parse_result_t found[$];
        logic [7:0]    saved_stack[256];
        int            saved_ptr;
        int            n_exp;
        int            ln;
        bit            done;
        logic [7:0]    sym;
        logic [8:0]    entry;
        logic [7:0]    prod;
        saved_stack = sym_stack;
        saved_ptr   = stack_ptr;
        n_exp = 0;
        done  = 0;
        ok    = 1;
        while (!done && ok)
        begin
            if (stack_ptr == 0)
            begin
                found.insert(found.size(), result_of(ST_EMPTY, 8'd0, 1'b1));
                done = 1;
            end
            else
            begin
                stack_ptr--;
                sym = sym_stack[stack_ptr];
                if (sym[7:6] == KIND_TERM)
                begin
                    found.insert(found.size(),
                                 result_of((sym[5:0] == lookahead) ? ST_MATCH : ST_MISMATCH,
                                           8'd0, 1'b1));
                    done = 1;
                end
                else if (sym[7:6] == KIND_NONTERM)
                begin
                    entry = grammar_table[{sym[5:0], lookahead}];
                    if (!entry[8])
                    begin
                        found.insert(found.size(), result_of(ST_MISS, 8'd0, 1'b1));
                        done = 1;
                    end
                    else if (n_exp >= EXPANSION_LIMIT)
                    begin
                        found.insert(found.size(), result_of(ST_OVERFLOW, 8'd0, 1'b1));
                        done = 1;
                    end
                    else
                    begin
                        prod = entry[7:0];
                        if (!rhs_len_known[prod])
                            ok = 0;
                        else
                        begin
                            ln = rhs_lens[prod];
                            for (int i = 0; i < ln; i++)
                                if (!rhs_sym_known[{prod, i[2:0]}])
                                    ok = 0;
                            if (ok && stack_ptr + ln > STACK_DEPTH)
                            begin
                                found.insert(found.size(),
                                             result_of(ST_OVERFLOW, 8'd0, 1'b1));
                                done = 1;
                            end
                            else if (ok)
                            begin
                                found.insert(found.size(), result_of(ST_EXPAND, prod, 1'b0));
                                n_exp++;
                                for (int i = ln - 1; i >= 0; i--)
                                begin
                                    sym_stack[stack_ptr] = rhs_syms[{prod, i[2:0]}];
                                    stack_ptr++;
                                end
                            end
                        end
                    end
                end
                // Null and reserved kinds are simply skipped.
            end
        end
        if (!ok)
        begin
            sym_stack = saved_stack;
            stack_ptr = saved_ptr;
        end
        else
        begin
            expansion_count += n_exp;
            foreach (found[i])
                expected_results.insert(expected_results.size(), found[i]);
        end
    endtask

    // Applies one item to the predictor and queues it for the driver if legal.
    task automatic issue(input load_item_t it, output bit ok);
        logic [3:0] sat_len;
        ok = 1;
        sat_len = (it.len > RHS_MAX) ? 4'(RHS_MAX) : it.len;
        case (it.opcode)
            OP_TABLE:
            begin
                grammar_table[{it.nt, it.term}] = it.ev ? {1'b1, it.prod} : 9'd0;
                expected_results.insert(expected_results.size(),
                                        result_of(ST_ACK, 8'd0, 1'b1));
            end
            OP_RHS:
            begin
                rhs_lens[it.prod]      = sat_len;
                rhs_len_known[it.prod] = 1;
                rhs_syms[{it.prod, it.pos}]      = {it.kind, it.sid};
                rhs_sym_known[{it.prod, it.pos}] = 1;
                expected_results.insert(expected_results.size(),
                                        result_of(ST_ACK, 8'd0, 1'b1));
            end
            OP_PUSH:
            begin
                if (stack_ptr >= STACK_DEPTH)
                    expected_results.insert(expected_results.size(),
                                            result_of(ST_OVERFLOW, 8'd0, 1'b1));
                else
                begin
                    sym_stack[stack_ptr] = {it.kind, it.sid};
                    stack_ptr++;
                    expected_results.insert(expected_results.size(),
                                            result_of(ST_ACK, 8'd0, 1'b1));
                end
            end
            default:
                run_parse(it.term, ok);
        endcase
        if (ok)
        begin
            pending_words.insert(pending_words.size(),
                                 {2'b00, it.sid, it.kind, it.len, it.pos, it.ev,
                                  it.prod, it.term, it.nt, it.opcode});
            item_count++;
        end
    endtask

    function automatic load_item_t make_item(op_t op, logic [5:0] nt, logic [5:0] term,
                                             logic [7:0] prod, logic ev, logic [2:0] pos,
                                             logic [3:0] len, logic [1:0] kind,
                                             logic [5:0] sid);
        load_item_t it;
        it = '{op, nt, term, prod, ev, pos, len, kind, sid};
        return it;
    endfunction

    // Random item, mostly within a small grammar so parses go deep.
    function automatic load_item_t random_item();
        load_item_t it;
        int         r;
        bit         wide;
        it.nt   = 6'($urandom);
        it.term = 6'($urandom);
        it.prod = 8'($urandom);
        it.ev   = 1'($urandom);
        it.pos  = 3'($urandom);
        it.len  = 4'($urandom);
        it.kind = 2'($urandom);
        it.sid  = 6'($urandom);
        wide = ($urandom_range(0, 9) == 0);
        r = $urandom_range(0, 99);
        if (r < 12)
            it.opcode = OP_TABLE;
        else if (r < 28)
            it.opcode = OP_RHS;
        else if (r < 45)
            it.opcode = OP_PUSH;
        else
            it.opcode = OP_PARSE;
        if (!wide)
        begin
            it.nt   = 6'($urandom_range(0, 3));
            it.term = 6'($urandom_range(0, 5));
            it.prod = 8'($urandom_range(0, 15));
            it.ev   = ($urandom_range(0, 9) != 0);
            it.len  = 4'($urandom_range(0, 4));
            it.sid  = 6'($urandom_range(0, 5));
            r = $urandom_range(0, 99);
            if (it.opcode == OP_PUSH)
                it.kind = (r < 75) ? KIND_NONTERM : (r < 90) ? KIND_TERM :
                          (r < 95) ? KIND_NULL : KIND_RSVD;
            else
                it.kind = (r < 35) ? KIND_NONTERM : (r < 85) ? KIND_TERM :
                          (r < 95) ? KIND_NULL : KIND_RSVD;
        end
        return it;
    endfunction

    // Stimulus: directed cases first, then random traffic.
    initial
    begin
        bit ok;
        int tries;
        error_count = 0;
        result_count = 0;
        item_count = 0;
        expansion_count = 0;
        stim_done = 0;
        quiet_stretch = 0;
        stack_ptr = 0;
        foreach (grammar_table[i])
            grammar_table[i] = 9'd0;

        // Self-recursive production: hits the expansion limit.
        issue(make_item(OP_RHS, 0, 0, 1, 0, 0, 1, KIND_NONTERM, 0), ok);
        issue(make_item(OP_TABLE, 0, 0, 1, 1, 0, 0, KIND_NULL, 0), ok);
        issue(make_item(OP_PUSH, 0, 0, 0, 0, 0, 0, KIND_NONTERM, 0), ok);
        issue(make_item(OP_PARSE, 0, 0, 0, 0, 0, 0, KIND_NULL, 0), ok);
        // Eight-symbol growth production: overflows the stack. The last write
        // carries an over-long length that must saturate.
        for (int i = 0; i < 8; i++)
            issue(make_item(OP_RHS, 0, 0, 2, 0, i, (i == 7) ? 4'd15 : 4'd8,
                            KIND_NONTERM, 1), ok);
        issue(make_item(OP_TABLE, 1, 1, 2, 1, 0, 0, KIND_NULL, 0), ok);
        issue(make_item(OP_RHS, 0, 0, 3, 0, 0, 0, KIND_NULL, 0), ok);
        issue(make_item(OP_TABLE, 1, 3, 3, 1, 0, 0, KIND_NULL, 0), ok);
        issue(make_item(OP_PUSH, 0, 0, 0, 0, 0, 0, KIND_NONTERM, 1), ok);
        issue(make_item(OP_PARSE, 0, 1, 0, 0, 0, 0, KIND_NULL, 0), ok);
        // Fill the stack completely, then push once more into a full stack.
        for (int i = 0; i < 5; i++)
            issue(make_item(OP_PUSH, 0, 0, 0, 0, 0, 0, KIND_NONTERM, 1), ok);
        // Empty productions drain the stack; the last parse sees it empty.
        for (int i = 0; i < 5; i++)
            issue(make_item(OP_PARSE, 0, 3, 0, 0, 0, 0, KIND_NULL, 0), ok);
        // Reserved kind skipped as null, then a terminal match and a mismatch.
        issue(make_item(OP_PUSH, 0, 0, 0, 0, 0, 0, KIND_TERM, 5), ok);
        issue(make_item(OP_PUSH, 0, 0, 0, 0, 0, 0, KIND_RSVD, 63), ok);
        issue(make_item(OP_PARSE, 0, 5, 0, 0, 0, 0, KIND_NULL, 0), ok);
        issue(make_item(OP_PUSH, 0, 0, 0, 0, 0, 0, KIND_TERM, 5), ok);
        issue(make_item(OP_PARSE, 0, 4, 0, 0, 0, 0, KIND_NULL, 0), ok);
        // Table miss, and a cleared entry that misses afterwards.
        issue(make_item(OP_PUSH, 0, 0, 0, 0, 0, 0, KIND_NONTERM, 2), ok);
        issue(make_item(OP_PARSE, 0, 0, 0, 0, 0, 0, KIND_NULL, 0), ok);
        issue(make_item(OP_TABLE, 0, 0, 0, 0, 0, 0, KIND_NULL, 0), ok);
        issue(make_item(OP_PUSH, 0, 0, 0, 0, 0, 0, KIND_NONTERM, 0), ok);
        issue(make_item(OP_PARSE, 0, 0, 0, 0, 0, 0, KIND_NULL, 0), ok);
        // Largest ids: empty production 255 at row 63, column 63.
        issue(make_item(OP_RHS, 0, 0, 255, 0, 7, 0, KIND_TERM, 63), ok);
        issue(make_item(OP_TABLE, 63, 63, 255, 1, 0, 0, KIND_NULL, 0), ok);
        issue(make_item(OP_PUSH, 0, 0, 0, 0, 0, 0, KIND_NONTERM, 63), ok);
        issue(make_item(OP_PARSE, 0, 63, 0, 0, 0, 0, KIND_NULL, 0), ok);

        // Random part; parses that would read unwritten rhs data are redrawn.
        tries = 0;
        while (item_count < DIRECTED_LIMIT && tries < 100000)
        begin
            issue(random_item(), ok);
            tries++;
        end
        stim_done = 1;
    end

    // Reset once at the start.
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Occasionally switch into or out of a stretch with no idling.
    always @(posedge clk)
        if ($urandom_range(0, 199) == 0)
            quiet_stretch <= !quiet_stretch;

    // Driver: presents pending words with random gaps between transfers.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                s_tdata  <= pending_words.pop_front();
                s_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: random back-pressure and checking of every result transfer.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d production %0d last %0b",
                           m_tdata[2:0], m_tdata[10:3], m_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[2:0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                        error_count++;
                    end
                    if (m_tdata[10:3] !== want.prod)
                    begin
                        $error("applied_production: expected %0d, got %0d",
                               want.prod, m_tdata[10:3]);
                        error_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready   <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    // End of run: all words sent, all results seen, then a short drain.
    initial
    begin
        wait (stim_done);
        @(posedge clk);
        while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (expected_results.size() > 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end
        $display("Covered %0d input items and %0d result transfers, %0d expansions,",
                 item_count, result_count, expansion_count);
        $display("including stack overflow, expansion limit, miss, mismatch and empty cases.");
        if (error_count == 0)
            $display("ll1_predictive_parse_step test passed");
        else
            $display("ll1_predictive_parse_step test failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #50ms;
        $display("ll1_predictive_parse_step test failed");
        $finish;
    end

endmodule
